/* hw/rtl/sha1he_pkg.sv */
// ----------------------------------------------------------------------------
// sha1he_pkg
// Shared types, constants and helpers for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1he_pkg;

   // Schedule window geometry
   localparam int unsigned WIN_DEPTH = 16;
   localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);
   localparam int unsigned ROUNDS    = 80;
   localparam int unsigned ROUND_W   = 7;
   localparam int unsigned DIGEST_WORDS = 5;

   // Slot that holds the high half of the length in the final block
   localparam logic [WIN_AW-1:0] LEN_HI_SLOT = 4'd14;
   localparam logic [WIN_AW-1:0] LAST_SLOT   = 4'd15;

   // Round constants
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   // Initial chain value
   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [31:0] PAD_ONE  = 32'h80000000;
   localparam logic [2:0]  FULL_CNT = 3'd4;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  byte_count;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } rsp_type;

   // Control from the sequencer to the schedule memory
   typedef struct packed {
      logic              wr_en;
      logic [WIN_AW-1:0] wr_addr;
      logic [31:0]       wr_data;
      logic [WIN_AW-1:0] rd_base;
      logic              rd_expand;
   } sched_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_PRIME,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   function automatic logic [31:0] init_h(input logic [2:0] i);
      logic [31:0] h;
      unique case (i)
         3'd0:    h = H0_INIT;
         3'd1:    h = H1_INIT;
         3'd2:    h = H2_INIT;
         3'd3:    h = H3_INIT;
         default: h = H4_INIT;
      endcase
      return h;
   endfunction

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

   function automatic logic [31:0] rotl5(input logic [31:0] x);
      return {x[26:0], x[31:27]};
   endfunction

   function automatic logic [31:0] rotl30(input logic [31:0] x);
      return {x[1:0], x[31:2]};
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/sha1he_sched.sv */
// ----------------------------------------------------------------------------
// sha1he_sched
// Message schedule window: two mirrored 16x32 memories, each read at two
// addresses per cycle, give the four taps of the W recurrence from registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1he_sched
   import sha1he_pkg::*;
(
   input  wire logic          clock,
   input  wire sched_ctl_type ctl,
   output logic [31:0]        w_out
);

   logic [31:0] mem0 [WIN_DEPTH];
   logic [31:0] mem1 [WIN_DEPTH];

   logic [31:0] tap0_ff, tap3_ff, tap8_ff, tap14_ff;
   logic        expand_ff;

   logic [WIN_AW-1:0] addr3, addr8, addr14;

   // Tap addresses relative to the round being fetched
   assign addr3  = ctl.rd_base - WIN_AW'(3);
   assign addr8  = ctl.rd_base - WIN_AW'(8);
   assign addr14 = ctl.rd_base - WIN_AW'(14);

   // Both copies take the same write; reads are registered
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem0[ctl.wr_addr] <= ctl.wr_data;
         mem1[ctl.wr_addr] <= ctl.wr_data;
      end
      tap0_ff   <= mem0[ctl.rd_base];
      tap3_ff   <= mem0[addr3];
      tap8_ff   <= mem1[addr8];
      tap14_ff  <= mem1[addr14];
      expand_ff <= ctl.rd_expand;
   end

   // Message word for the round: stored word, or the expanded one
   assign w_out = expand_ff ? rotl1(tap0_ff ^ tap3_ff ^ tap8_ff ^ tap14_ff) : tap0_ff;

endmodule

`default_nettype wire

/* hw/rtl/sha1_hash_engine_unit.sv */
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// SHA-1 digest of a word stream, with padding and length append.
// ----------------------------------------------------------------------------
// Words are taken one per cycle until a 512-bit block is full; the block then
// runs its compression, one round per cycle through the schedule memory
// (a priming state, 80 rounds, a chain update) during which req_stall is
// high. On the last word the engine writes the pad and length words one per
// cycle (one or two more compressions) and then presents the five digest
// words, h0 first, one per rsp transaction; the next message is taken once
// the fifth word has gone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_hash_engine_unit
   import sha1he_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_data,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   state_type state_ff, state_in;

   logic [31:0]        chain_ff [DIGEST_WORDS];
   logic [31:0]        chain_in [DIGEST_WORDS];
   logic [31:0]        wv_ff    [DIGEST_WORDS];
   logic [31:0]        wv_in    [DIGEST_WORDS];
   logic [63:0]        len_ff, len_in;
   logic [WIN_AW-1:0]  wic_ff, wic_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [2:0]         idx_ff, idx_in;
   logic               pad_one_ff, pad_one_in;
   logic               pad_act_ff, pad_act_in;
   logic               len_lo_ff, len_lo_in;
   logic               done_ff, done_in;

   sched_ctl_type      sched_ctl;
   logic [31:0]        w_round;

   logic               req_acc;
   logic               rsp_acc;
   logic [2:0]         cnt_sat;
   logic [31:0]        keep_mask;
   logic [31:0]        pad_bit;
   logic [31:0]        in_word;
   logic [31:0]        pad_word;
   logic [ROUND_W-1:0] round_next;
   logic [31:0]        f_val;
   logic [31:0]        k_val;
   logic [31:0]        t_sum;

   assign req_acc    = req_valid && !req_stall;
   assign rsp_acc    = rsp_valid && !rsp_stall;
   assign round_next = round_ff + ROUND_W'(1);

   // Last-word byte handling
   assign cnt_sat = (req_data.byte_count > FULL_CNT) ? FULL_CNT : req_data.byte_count;

   always_comb begin
      unique case (cnt_sat)
         3'd0: begin
            keep_mask = 32'h00000000;
            pad_bit   = 32'h80000000;
         end
         3'd1: begin
            keep_mask = 32'hFF000000;
            pad_bit   = 32'h00800000;
         end
         3'd2: begin
            keep_mask = 32'hFFFF0000;
            pad_bit   = 32'h00008000;
         end
         3'd3: begin
            keep_mask = 32'hFFFFFF00;
            pad_bit   = 32'h00000080;
         end
         default: begin
            keep_mask = 32'hFFFFFFFF;
            pad_bit   = 32'h00000000;
         end
      endcase
   end

   assign in_word = (req_data.last_word && cnt_sat != FULL_CNT)
                    ? ((req_data.message_word & keep_mask) | pad_bit)
                    : req_data.message_word;

   // Pad word for the current slot
   always_comb begin
      priority if (pad_one_ff) begin
         pad_word = PAD_ONE;
      end else if (len_lo_ff) begin
         pad_word = len_ff[31:0];
      end else if (wic_ff == LEN_HI_SLOT) begin
         pad_word = len_ff[63:32];
      end else begin
         pad_word = 32'h0;
      end
   end

   // Round function and constant
   always_comb begin
      priority if (round_ff < ROUND_W'(20)) begin
         f_val = (wv_ff[1] & wv_ff[2]) | (~wv_ff[1] & wv_ff[3]);
         k_val = K0;
      end else if (round_ff < ROUND_W'(40)) begin
         f_val = wv_ff[1] ^ wv_ff[2] ^ wv_ff[3];
         k_val = K1;
      end else if (round_ff < ROUND_W'(60)) begin
         f_val = (wv_ff[1] & wv_ff[2]) | (wv_ff[1] & wv_ff[3]) | (wv_ff[2] & wv_ff[3]);
         k_val = K2;
      end else begin
         f_val = wv_ff[1] ^ wv_ff[2] ^ wv_ff[3];
         k_val = K3;
      end
   end

   assign t_sum = rotl5(wv_ff[0]) + f_val + wv_ff[4] + k_val + w_round;

   // Schedule window
   sha1he_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_out (w_round)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               priority if (wic_ff == LAST_SLOT) begin
                  state_in = ST_PRIME;
               end else if (req_data.last_word) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            if (wic_ff == LAST_SLOT) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == ROUND_W'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            priority if (done_ff) begin
               state_in = ST_OUT;
            end else if (pad_act_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_acc && idx_ff == 3'(DIGEST_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: handshake and schedule memory control
   always_comb begin
      req_stall           = 1'b1;
      rsp_valid           = 1'b0;
      sched_ctl.wr_en     = 1'b0;
      sched_ctl.wr_addr   = wic_ff;
      sched_ctl.wr_data   = in_word;
      sched_ctl.rd_base   = round_next[WIN_AW-1:0];
      sched_ctl.rd_expand = (round_next >= ROUND_W'(WIN_DEPTH));
      unique case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            sched_ctl.wr_en = req_valid;
         end
         ST_PAD: begin
            sched_ctl.wr_en   = 1'b1;
            sched_ctl.wr_data = pad_word;
         end
         ST_PRIME: begin
            sched_ctl.rd_base   = '0;
            sched_ctl.rd_expand = 1'b0;
         end
         ST_ROUND: begin
            sched_ctl.wr_en   = 1'b1;
            sched_ctl.wr_addr = round_ff[WIN_AW-1:0];
            sched_ctl.wr_data = w_round;
         end
         ST_FOLD: begin
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Result payload
   assign rsp_data.digest_word = chain_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.digest_last = (idx_ff == 3'(DIGEST_WORDS - 1));

   // Datapath register updates
   always_comb begin
      chain_in   = chain_ff;
      wv_in      = wv_ff;
      len_in     = len_ff;
      wic_in     = wic_ff;
      round_in   = round_ff;
      idx_in     = idx_ff;
      pad_one_in = pad_one_ff;
      pad_act_in = pad_act_ff;
      len_lo_in  = len_lo_ff;
      done_in    = done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               wic_in = wic_ff + WIN_AW'(1);
               if (req_data.last_word) begin
                  len_in     = len_ff + 64'({cnt_sat, 3'b000});
                  pad_one_in = (cnt_sat == FULL_CNT);
                  pad_act_in = 1'b1;
               end else begin
                  len_in = len_ff + 64'd32;
               end
            end
         end
         ST_PAD: begin
            wic_in     = wic_ff + WIN_AW'(1);
            pad_one_in = 1'b0;
            if (!pad_one_ff) begin
               if (len_lo_ff) begin
                  len_lo_in = 1'b0;
                  done_in   = 1'b1;
               end else if (wic_ff == LEN_HI_SLOT) begin
                  len_lo_in = 1'b1;
               end
            end
         end
         ST_PRIME: begin
            wv_in    = chain_ff;
            round_in = '0;
         end
         ST_ROUND: begin
            wv_in[4] = wv_ff[3];
            wv_in[3] = wv_ff[2];
            wv_in[2] = rotl30(wv_ff[1]);
            wv_in[1] = wv_ff[0];
            wv_in[0] = t_sum;
            round_in = round_next;
         end
         ST_FOLD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + wv_ff[i];
            end
            round_in = '0;
         end
         ST_OUT: begin
            if (rsp_acc) begin
               if (idx_ff == 3'(DIGEST_WORDS - 1)) begin
                  idx_in     = '0;
                  len_in     = '0;
                  wic_in     = '0;
                  pad_act_in = 1'b0;
                  done_in    = 1'b0;
                  for (int i = 0; i < DIGEST_WORDS; i++) begin
                     chain_in[i] = init_h(3'(i));
                  end
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_ff     <= '0;
         wic_ff     <= '0;
         round_ff   <= '0;
         idx_ff     <= '0;
         pad_one_ff <= 1'b0;
         pad_act_ff <= 1'b0;
         len_lo_ff  <= 1'b0;
         done_ff    <= 1'b0;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= init_h(3'(i));
            wv_ff[i]    <= '0;
         end
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         wic_ff     <= wic_in;
         round_ff   <= round_in;
         idx_ff     <= idx_in;
         pad_one_ff <= pad_one_in;
         pad_act_ff <= pad_act_in;
         len_lo_ff  <= len_lo_in;
         done_ff    <= done_in;
         chain_ff   <= chain_in;
         wv_ff      <= wv_in;
      end
   end

endmodule

`default_nettype wire

/* test/sha1_hash_engine_unit_test.sv */
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit_test
// Self-checking testbench for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
// Messages stream in as words on the req channel. A behavioral SHA-1 model
// in this file tracks the chain value, schedule window and bit length, and
// queues the five digest words that each last word must produce. Every rsp
// transaction is checked field by field against the oldest queued word.
// Directed messages cover the empty message, short and saturated byte counts,
// ignored counts on non-last words and padding that spills into a second
// block. Random messages follow under three stall mixes: a slow receiver,
// a slow sender, and no idling on either side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_hash_engine_unit_test;
   import sha1he_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 200;

   // SHA-1 round constants and initial chain value
   localparam logic [31:0] ROUND_K_0 = 32'h5A827999;
   localparam logic [31:0] ROUND_K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] ROUND_K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] ROUND_K_3 = 32'hCA62C1D6;
   localparam logic [31:0] CHAIN_INIT [5] = '{32'h67452301, 32'hEFCDAB89,
                                              32'h98BADCFE, 32'h10325476,
                                              32'hC3D2E1F0};
   localparam logic [31:0] PAD_MARKER = 32'h80000000;
   localparam logic [2:0]  FULL_BYTES = 3'd4;
   localparam logic [3:0]  LENGTH_SLOT = 4'd14;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int req_idle_pct   = 21;
   int rsp_idle_pct   = 88;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // Model state
   logic [31:0] digest_chain [5];
   logic [31:0] sched_win [16];
   logic [63:0] msg_bits;
   logic [3:0]  win_slot;
   rsp_type     expected_digest [$];

   sha1_hash_engine_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digest words outstanding",
                  cycle_count, expected_digest.size());
         $display("sha1_hash_engine_unit_test: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // SHA-1 model
   // ------------------------------------------------------------------------
   task automatic restart_message();
      for (int i = 0; i < 5; i++) digest_chain[i] = CHAIN_INIT[i];
      msg_bits = '0;
      win_slot = '0;
   endtask

   task automatic compress_window();
      logic [31:0] a, b, c, d, e, f, k, w, sum;
      a = digest_chain[0];
      b = digest_chain[1];
      c = digest_chain[2];
      d = digest_chain[3];
      e = digest_chain[4];
      for (int t = 0; t < 80; t++) begin
         // rolling schedule expansion past round 15
         if (t >= 16) begin
            w = sched_win[(t + 13) % 16] ^ sched_win[(t + 8) % 16]
              ^ sched_win[(t + 2) % 16] ^ sched_win[t % 16];
            w = {w[30:0], w[31]};
            sched_win[t % 16] = w;
         end else begin
            w = sched_win[t];
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = ROUND_K_0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = ROUND_K_1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = ROUND_K_2;
         end else begin
            f = b ^ c ^ d;
            k = ROUND_K_3;
         end
         sum = {a[26:0], a[31:27]} + f + e + k + w;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      digest_chain[0] += a;
      digest_chain[1] += b;
      digest_chain[2] += c;
      digest_chain[3] += d;
      digest_chain[4] += e;
   endtask

   task automatic absorb_word(input logic [31:0] w);
      sched_win[win_slot] = w;
      win_slot = win_slot + 4'd1;
      if (win_slot == 4'd0) compress_window();
   endtask

   // Update the model with one accepted word; a last word queues the digest
   task automatic predict_digest(input req_type item);
      logic [2:0]  nbytes;
      logic [31:0] keep;
      rsp_type     dword;
      if (!item.last_word) begin
         // byte count is ignored on non-last words
         msg_bits += 64'd32;
         absorb_word(item.message_word);
      end else begin
         nbytes = (item.byte_count > FULL_BYTES) ? FULL_BYTES : item.byte_count;
         msg_bits += {58'd0, nbytes, 3'd0};
         if (nbytes == FULL_BYTES) begin
            absorb_word(item.message_word);
            absorb_word(PAD_MARKER);
         end else begin
            keep = (nbytes == 3'd0) ? 32'd0 : ~(32'hFFFFFFFF >> (8 * nbytes));
            absorb_word((item.message_word & keep) | (PAD_MARKER >> (8 * nbytes)));
         end
         while (win_slot != LENGTH_SLOT) absorb_word(32'd0);
         absorb_word(msg_bits[63:32]);
         absorb_word(msg_bits[31:0]);
         for (int i = 0; i < 5; i++) begin
            dword.digest_word = digest_chain[i];
            dword.word_index  = 3'(i);
            dword.digest_last = (i == 4);
            expected_digest = {expected_digest, dword};
         end
         restart_message();
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   task automatic send_word(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_digest(item);
   endtask

   task automatic send_fields(input logic [31:0] w, input logic [2:0] nbytes,
                              input logic last);
      req_type item;
      item.message_word = w;
      item.byte_count   = nbytes;
      item.last_word    = last;
      send_word(item);
   endtask

   // Receiver back-pressure
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

   // ------------------------------------------------------------------------
   // Digest checker
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("ERROR @%0t: %s expected %h got %h", $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_digest
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digest.size() == 0) begin
            report_mismatch("unexpected digest word", 32'd0, rsp_data.digest_word);
         end else begin
            want = expected_digest.pop_front();
            if (rsp_data.digest_word !== want.digest_word)
               report_mismatch("digest_word", want.digest_word, rsp_data.digest_word);
            if (rsp_data.word_index !== want.word_index)
               report_mismatch("word_index", 32'(want.word_index),
                               32'(rsp_data.word_index));
            if (rsp_data.digest_last !== want.digest_last)
               report_mismatch("digest_last", 32'(want.digest_last),
                               32'(rsp_data.digest_last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Zero-length message; the data bits must be dropped
   task automatic test_empty_message();
      send_fields(32'hFFFFFFFF, 3'd0, 1'b1);
   endtask

   // One-word messages with each partial and full byte count
   task automatic test_short_messages();
      send_fields(32'hFFFFFFFF, 3'd1, 1'b1);
      send_fields(32'h00000000, 3'd2, 1'b1);
      send_fields(32'hFFFFFFFF, 3'd3, 1'b1);
      send_fields(32'h00000000, 3'd4, 1'b1);
   endtask

   // Last-word counts above four act as four
   task automatic test_count_saturation();
      send_fields(32'hA5A5C3C3, 3'd5, 1'b1);
      send_fields(32'hFFFFFFFF, 3'd7, 1'b1);
   endtask

   // Non-last words always carry four bytes whatever their count says
   task automatic test_ignored_count();
      send_fields(32'h00000000, 3'd0, 1'b0);
      send_fields(32'hFFFFFFFF, 3'd7, 1'b0);
      send_fields(32'h12345678, 3'd4, 1'b1);
   endtask

   // Pad marker lands on slot 14, so length goes into an extra block
   task automatic test_two_block_padding();
      for (int i = 0; i < 13; i++)
         send_fields(i[0] ? 32'hFFFFFFFF : 32'($urandom), 3'd4, 1'b0);
      send_fields(32'hFFFFFFFF, 3'd4, 1'b1);
   endtask

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(15))
         0:       w = 32'h00000000;
         1:       w = 32'hFFFFFFFF;
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // Random-length messages, mostly short, sometimes several blocks
   task automatic test_random_messages(input int item_budget);
      int sent;
      int msg_words;
      sent = 0;
      while (sent < item_budget) begin
         msg_words = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(18);
         for (int i = 0; i < msg_words; i++)
            send_fields(pick_word(),
                        ($urandom_range(6) == 0) ? 3'($urandom_range(7)) : FULL_BYTES,
                        1'b0);
         send_fields(pick_word(), 3'($urandom_range(7)), 1'b1);
         sent += msg_words + 1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      restart_message();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_message();
      test_short_messages();
      test_count_saturation();
      test_ignored_count();
      test_two_block_padding();
      test_random_messages(86);

      req_idle_pct = 88;
      rsp_idle_pct = 21;
      test_random_messages(86);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_messages(86);

      req_valid <= 1'b0;
      while (expected_digest.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("sha1_hash_engine_unit_test: PASS");
      end else begin
         $display("sha1_hash_engine_unit_test: FAIL");
      end
      $finish;
   end

endmodule
